// ===== rtl/dct32_pkg.sv =====
// ============================================================================
// dct32_pkg
// Shared types, constants and basis function of the 32-point forward DCT row.
// ============================================================================
package dct32_pkg;

    localparam int POINTS  = 32;
    localparam int IDX_W   = $clog2(POINTS);
    localparam int SMP_W   = 16;
    localparam int SHIFT_W = 5;
    localparam int ACC_W   = 28;
    // rounding sum: holds the accumulator plus a rounding term of up to 1 << 30
    localparam int RND_W   = ACC_W + 5;
    localparam int COEF_W  = 8;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd4;
    localparam logic [0:0] REG_SHIFT = 1'b0;

    typedef enum logic [1:0] {
        t_ST_FILL,
        t_ST_MAC,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_rd_ctrl;

    function automatic logic signed [COEF_W-1:0] cos_mag(input logic [5:0] m);
        logic signed [COEF_W-1:0] v;
        begin
            unique case (m)
                6'd0:  v = 8'sd64;  6'd1:  v = 8'sd90;  6'd2:  v = 8'sd90;
                6'd3:  v = 8'sd90;  6'd4:  v = 8'sd89;  6'd5:  v = 8'sd88;
                6'd6:  v = 8'sd87;  6'd7:  v = 8'sd85;  6'd8:  v = 8'sd83;
                6'd9:  v = 8'sd82;  6'd10: v = 8'sd80;  6'd11: v = 8'sd78;
                6'd12: v = 8'sd75;  6'd13: v = 8'sd73;  6'd14: v = 8'sd70;
                6'd15: v = 8'sd67;  6'd16: v = 8'sd64;  6'd17: v = 8'sd61;
                6'd18: v = 8'sd57;  6'd19: v = 8'sd54;  6'd20: v = 8'sd50;
                6'd21: v = 8'sd46;  6'd22: v = 8'sd43;  6'd23: v = 8'sd38;
                6'd24: v = 8'sd36;  6'd25: v = 8'sd31;  6'd26: v = 8'sd25;
                6'd27: v = 8'sd22;  6'd28: v = 8'sd18;  6'd29: v = 8'sd13;
                6'd30: v = 8'sd9;   6'd31: v = 8'sd4;
                default: v = 8'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] basis(input logic [IDX_W-1:0] k,
                                                      input logic [IDX_W-1:0] n);
        logic [6:0] m;
        logic [6:0] odd;
        logic [13:0] prod;
        begin
            odd  = {n, 1'b1};
            prod = {7'd0, 2'b00, k} * {7'd0, odd};
            m    = prod[6:0];
            if (m > 7'd64) m = 7'd0 - m;
            if (m > 7'd32) return -cos_mag(6'(7'd64 - m));
            return cos_mag(m[5:0]);
        end
    endfunction

endpackage

// ===== rtl/dct32_ram.sv =====
// ============================================================================
// dct32_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module dct32_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/dct32_mac.sv =====
// ============================================================================
// dct32_mac
// Multiply-accumulate datapath: one sample times one basis entry per cycle,
// then round, shift and wrap.
// ============================================================================
module dct32_mac (
    input  logic                              i_clk,
    input  logic                              i_clear,
    input  logic                              i_mul_en,
    input  logic signed [dct32_pkg::SMP_W-1:0]  i_sample,
    input  logic signed [dct32_pkg::COEF_W-1:0] i_coef,
    input  logic                              i_acc_en,
    input  logic [dct32_pkg::SHIFT_W-1:0]      i_shift,
    output logic signed [dct32_pkg::SMP_W-1:0]  o_result
);
    import dct32_pkg::*;

    logic signed [SMP_W+COEF_W-1:0] r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [RND_W-1:0]        rnd;
    logic signed [RND_W-1:0]        shifted;

    always_ff @(posedge i_clk) begin
        if (i_mul_en) r_prod <= i_sample * i_coef;
        if (i_clear) r_acc <= '0;
        else if (i_acc_en) r_acc <= r_acc + ACC_W'(r_prod);
    end

    always_comb begin
        rnd = RND_W'(r_acc);
        if (i_shift != '0) rnd = rnd + (RND_W'(1) <<< (i_shift - 1'b1));
        shifted = rnd >>> i_shift;
    end

    assign o_result = shifted[SMP_W-1:0];
endmodule

// ===== rtl/dct_32x32_forward_stage.sv =====
// ============================================================================
// dct_32x32_forward_stage
// One 32-point forward integer DCT row pass over a 32x32 block.
// ============================================================================
// Input channel: i_valid/o_stall carry one signed sample per transfer, with
// i_zero_row looked at on the row's 32nd sample. Output channel:
// o_valid/i_stall carry one coefficient per transfer with its index k, the
// row number, last (k = 31) and block_done (k = 31 of row 31).
// Samples fill a 32-entry row RAM at one per cycle. After the 32nd sample
// the input stalls while each coefficient is computed on a single
// multiplier, through the RAM read register, product register and
// accumulator, then the result sits in the output register until taken. A
// row is thus done only when all 32 coefficients have been taken; the shared
// multiply-accumulate loop sets the row rate.
// Zero rows skip the loop and give zero coefficients.
// Reset clears counters, state and the shift register (to 4); the row RAM
// holds garbage until written. A stalled output holds its value and the
// block waits. Shift is written over the APB port at address 0.
// ============================================================================
module dct_32x32_forward_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_sample,
    input  logic        i_zero_row,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_coefficient,
    output logic [4:0]  o_coeff_index,
    output logic [4:0]  o_row_index,
    output logic        o_last,
    output logic        o_block_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dct32_pkg::*;

    t_state r_state, n_state;
    logic [IDX_W-1:0]   r_scount, r_rcount, r_k, r_n;
    logic [IDX_W:0]     r_step;
    logic               r_zero;
    logic [SHIFT_W-1:0] r_shift;
    logic               r_ovalid;
    logic [SMP_W-1:0]   r_coef;
    logic [IDX_W-1:0]   r_ok, r_orow;
    logic               r_olast, r_odone;
    logic               r_v1, r_v2;
    logic [IDX_W-1:0]   r_n1;
    t_rd_ctrl           rd;
    logic               in_acc, out_acc, mac_done;
    logic [SMP_W-1:0]   rdata;
    logic signed [SMP_W-1:0] mac_res;

    assign pready = 1'b1;
    assign prdata = {{(32-SHIFT_W){1'b0}}, r_shift};
    assign o_stall = (r_state != t_ST_FILL);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign mac_done = (r_state == t_ST_MAC) && (r_step == (IDX_W+1)'(POINTS + 2));

    always_comb begin
        rd.rd_en   = (r_state == t_ST_MAC) && !r_zero;
        rd.rd_addr = r_n;
    end

    dct32_ram #(.WIDTH(SMP_W), .DEPTH(POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_scount),
        .i_wdata (i_sample),
        .i_re    (rd.rd_en),
        .i_raddr (rd.rd_addr),
        .o_rdata (rdata)
    );

    dct32_mac u_mac (
        .i_clk    (i_clk),
        .i_clear  (r_state != t_ST_MAC),
        .i_mul_en (r_v1),
        .i_sample (signed'(rdata)),
        .i_coef   (basis(r_k, r_n1)),
        .i_acc_en (r_v2),
        .i_shift  (r_shift),
        .o_result (mac_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_FILL: if (in_acc && r_scount == IDX_W'(POINTS-1)) n_state = t_ST_MAC;
            t_ST_MAC:  if (r_zero || mac_done) n_state = t_ST_OUT;
            t_ST_OUT:  if (out_acc) n_state = (r_ok == IDX_W'(POINTS-1)) ? t_ST_FILL : t_ST_MAC;
            default:   n_state = t_ST_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_ST_FILL;
            r_scount <= '0;
            r_rcount <= '0;
            r_k      <= '0;
            r_n      <= '0;
            r_step   <= '0;
            r_shift  <= SHIFT_RESET;
            r_ovalid <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_zero   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr[2] == REG_SHIFT && paddr[1:0] == 2'b00)
                r_shift <= pwdata[SHIFT_W-1:0];
            if (in_acc) begin
                r_scount <= r_scount + 1'b1;
                if (r_scount == IDX_W'(POINTS-1)) begin
                    r_zero <= i_zero_row;
                    r_k    <= '0;
                end
            end
            r_v1 <= rd.rd_en && r_step < (IDX_W+1)'(POINTS);
            r_v2 <= r_v1;
            r_n1 <= r_n;
            if (r_state == t_ST_MAC) begin
                r_n    <= r_n + 1'b1;
                r_step <= r_step + 1'b1;
            end else begin
                r_n    <= '0;
                r_step <= '0;
            end
            if (r_state == t_ST_MAC && (r_zero || mac_done)) begin
                r_ovalid <= 1'b1;
                r_coef   <= r_zero ? '0 : mac_res;
                r_ok     <= r_k;
                r_orow   <= r_rcount;
                r_olast  <= (r_k == IDX_W'(POINTS-1));
                r_odone  <= (r_k == IDX_W'(POINTS-1)) && (r_rcount == IDX_W'(POINTS-1));
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
                r_k      <= r_k + 1'b1;
                if (r_ok == IDX_W'(POINTS-1)) r_rcount <= r_rcount + 1'b1;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_coefficient = r_coef;
    assign o_coeff_index = r_ok;
    assign o_row_index   = r_orow;
    assign o_last        = r_olast;
    assign o_block_done  = r_odone;

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != t_ST_FILL) |-> !in_acc) else $error("input taken while busy");
    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == t_ST_OUT)) else $error("valid outside output state");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odone) |-> r_olast) else $error("block_done without last");
`endif
endmodule

// ===== tb/tb_dct_32x32_forward_stage.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_dct_32x32_forward_stage
// Streams whole rows of samples into the 32-point forward DCT row stage and
// checks every coefficient against a behavioral dot-product predictor. Covers
// extreme rows, zero rows, shifts of 0, 4, 20 and 31, random idling on both
// channels and a long output hold-off.
// ============================================================================

typedef struct {
    logic [15:0] coefficient;
    logic [4:0]  coeff_index;
    logic [4:0]  row_index;
    logic        last;
    logic        block_done;
} coeff_t;

class dct_row_scoreboard;
    int                  cos_lut[33];
    logic signed [15:0]  row_buf[32];
    int                  col;
    logic [4:0]          row_num;
    logic [4:0]          shift_amt;
    coeff_t              pending[$];
    int                  errors;

    function new();
        cos_lut = '{64, 90, 90, 90, 89, 88, 87, 85, 83, 82, 80, 78, 75, 73, 70, 67,
                    64, 61, 57, 54, 50, 46, 43, 38, 36, 31, 25, 22, 18, 13, 9, 4, 0};
        col       = 0;
        row_num   = 0;
        shift_amt = 5'd4;
        errors    = 0;
    endfunction

    function int basis_entry(int k, int n);
        int m;
        m = (k * (2 * n + 1)) % 128;
        if (m > 64) m = 128 - m;
        if (m > 32) return -cos_lut[(64 - m) % 64];
        return cos_lut[m];
    endfunction

    function void note_sample(logic [15:0] s, logic z);
        coeff_t      c;
        longint      acc;
        longint      rnd;
        row_buf[col] = s;
        if (col < 31) begin
            col++;
            return;
        end
        col = 0;
        rnd = (shift_amt == 0) ? 64'sd0 : (64'sd1 <<< (shift_amt - 1));
        for (int k = 0; k < 32; k++) begin
            acc = 0;
            if (!z) begin
                for (int n = 0; n < 32; n++)
                    acc += longint'(basis_entry(k, n)) * longint'(row_buf[n]);
                acc = (acc + rnd) >>> shift_amt;
            end
            c.coefficient = acc[15:0];
            c.coeff_index = k[4:0];
            c.row_index   = row_num;
            c.last        = (k == 31);
            c.block_done  = (k == 31) && (row_num == 5'd31);
            pending.push_back(c);
        end
        row_num++;
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    task check_coeff(coeff_t got);
        coeff_t want;
        if (pending.size() == 0) begin
            report($sformatf("unexpected coefficient k=%0d row=%0d",
                             got.coeff_index, got.row_index));
            return;
        end
        want = pending.pop_front();
        if (got.coefficient !== want.coefficient)
            report($sformatf("coefficient row=%0d k=%0d got %0d want %0d", want.row_index,
                             want.coeff_index, $signed(got.coefficient),
                             $signed(want.coefficient)));
        if (got.coeff_index !== want.coeff_index)
            report($sformatf("coeff_index got %0d want %0d", got.coeff_index,
                             want.coeff_index));
        if (got.row_index !== want.row_index)
            report($sformatf("row_index got %0d want %0d", got.row_index, want.row_index));
        if (got.last !== want.last)
            report($sformatf("last got %0b want %0b k=%0d", got.last, want.last,
                             want.coeff_index));
        if (got.block_done !== want.block_done)
            report($sformatf("block_done got %0b want %0b k=%0d row=%0d", got.block_done,
                             want.block_done, want.coeff_index, want.row_index));
    endtask
endclass

module tb_dct_32x32_forward_stage;

    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_sample;
    logic        i_zero_row;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_coefficient;
    logic [4:0]  o_coeff_index;
    logic [4:0]  o_row_index;
    logic        o_last;
    logic        o_block_done;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dct_row_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;
    int  cycle_cnt;

    dct_32x32_forward_stage dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_zero_row    (i_zero_row),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coefficient (o_coefficient),
        .o_coeff_index (o_coeff_index),
        .o_row_index   (o_row_index),
        .o_last        (o_last),
        .o_block_done  (o_block_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_dct_32x32_forward_stage failed");
            $finish;
        end
    end

    // receiver side: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        coeff_t got;
        if (i_rst_n && i_valid && !o_stall)
            sb.note_sample(i_sample, i_zero_row);
        if (i_rst_n && o_valid && !i_stall) begin
            got.coefficient = o_coefficient;
            got.coeff_index = o_coeff_index;
            got.row_index   = o_row_index;
            got.last        = o_last;
            got.block_done  = o_block_done;
            sb.check_coeff(got);
        end
    end

    task send_sample(logic [15:0] s, logic z);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_sample   <= s;
        i_zero_row <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // kind: 0 random full range, 1 small values, 2 all max, 3 all min, 4 alternating
    task send_row(int kind, logic zero_last);
        logic [15:0] s;
        for (int n = 0; n < 32; n++) begin
            case (kind)
                0: s = 16'($urandom);
                1: s = 16'($urandom_range(511)) - 16'd256;
                2: s = 16'h7fff;
                3: s = 16'h8000;
                default: s = n[0] ? 16'h8000 : 16'h7fff;
            endcase
            send_sample(s, (n == 31) ? zero_last : 1'($urandom));
        end
    endtask

    task drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task write_shift(logic [4:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(dct32_pkg::REG_SHIFT) << 2;
        pwdata  <= {27'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.shift_amt = val;
        @(posedge i_clk);
    endtask

    task random_rows(int count);
        for (int r = 0; r < count; r++)
            send_row($urandom_range(4) == 0 ? 1 : 0, $urandom_range(99) < 60);
    endtask

    initial begin
        sb            = new();
        cycle_cnt     = 0;
        hold_cycles   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample      = 16'd0;
        i_zero_row    = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset shift
        send_row(2, 1'b0);
        send_row(0, 1'b1);
        drain();

        send_idle_pct = 13;
        recv_idle_pct = 46;
        write_shift(5'd20);
        hold_cycles = 2500;
        send_row(3, 1'b0);
        random_rows(1);
        drain();

        send_idle_pct = 46;
        recv_idle_pct = 13;
        write_shift(5'd31);
        send_row(4, 1'b0);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_shift(5'd0);
        random_rows(1);
        drain();
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0)
            $display("tb_dct_32x32_forward_stage passed");
        else
            $display("tb_dct_32x32_forward_stage failed");
        $finish;
    end

endmodule
